// ===== rtl/smi_pkg.sv =====
// shared types, constants and helpers of the stack machine interpreter core
// no dependencies; imported by every module of the block but smi_ram and smi_checker
package smi_pkg;

  localparam int CELL_BITS    = 32;
  localparam int NUM_LINES    = 64;
  localparam int LINE_CELLS   = 32;
  localparam int DATA_DEPTH   = 64;
  localparam int RETURN_DEPTH = 64;

  localparam int FIRST_USER = 21;
  localparam int CALL_MARK  = 42;
  localparam int FAR_LINE   = 255;

  localparam int LINE_W     = 8;
  localparam int RET_W      = 8;
  localparam int LN_AW      = $clog2(NUM_LINES);
  localparam int LEN_W      = $clog2(LINE_CELLS + 1);
  localparam int COL_W      = LEN_W;
  localparam int LIU_W      = $clog2(NUM_LINES + 1);
  localparam int PROG_DEPTH = NUM_LINES * LINE_CELLS;
  localparam int PROG_AW    = $clog2(PROG_DEPTH);
  localparam int DS_AW      = $clog2(DATA_DEPTH);
  localparam int DC_W       = $clog2(DATA_DEPTH + 1);
  localparam int RS_AW      = $clog2(RETURN_DEPTH);
  localparam int RC_W       = $clog2(RETURN_DEPTH + 1);
  localparam int IN_TW      = 48;
  localparam int OUT_TW     = 48;
  localparam int OPC_W      = 5;

  // intrinsic opcodes, exit covers everything from 14 to 20
  localparam logic [OPC_W-1:0] IN_ADD  = 5'd0;
  localparam logic [OPC_W-1:0] IN_SUB  = 5'd1;
  localparam logic [OPC_W-1:0] IN_MUL  = 5'd2;
  localparam logic [OPC_W-1:0] IN_DIV  = 5'd3;
  localparam logic [OPC_W-1:0] IN_MOD  = 5'd4;
  localparam logic [OPC_W-1:0] IN_AND  = 5'd5;
  localparam logic [OPC_W-1:0] IN_OR   = 5'd6;
  localparam logic [OPC_W-1:0] IN_NOT  = 5'd7;
  localparam logic [OPC_W-1:0] IN_SWAP = 5'd8;
  localparam logic [OPC_W-1:0] IN_DUP  = 5'd9;
  localparam logic [OPC_W-1:0] IN_DROP = 5'd10;
  localparam logic [OPC_W-1:0] IN_LOOP = 5'd11;
  localparam logic [OPC_W-1:0] IN_EMIT = 5'd12;
  localparam logic [OPC_W-1:0] IN_READ = 5'd13;

  typedef enum logic [1:0] {
    OPN_COMPILE = 2'd0,
    OPN_STEP    = 2'd1,
    OPN_SETIP   = 2'd2,
    OPN_NOP     = 2'd3
  } oper_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EXIT    = 3'd1,
    ST_DUNDER  = 3'd2,
    ST_RUNDER  = 3'd3,
    ST_DOVER   = 3'd4,
    ST_ROVER   = 3'd5,
    ST_DROPPED = 3'd6,
    ST_HALTED  = 3'd7
  } status_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_LATCH, DP_SET_IP, DP_RESTART, DP_COMPILE,
    DP_RET_RD1, DP_RET_RD2, DP_RET_DONE, DP_PROG_RD, DP_PUSH_CELL,
    DP_POP_RD, DP_OPC, DP_CALL1, DP_CALL2, DP_BIN1, DP_ALU,
    DP_DIVCAP, DP_WB, DP_NOT, DP_SW2, DP_SW3, DP_DUP, DP_DROP,
    DP_LOOP, DP_EMIT, DP_READ, DP_EXIT, DP_DONE
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_CMP1, S_STEP1, S_RET1, S_RET2, S_CELL, S_OPC,
    S_DEC, S_CALL2, S_BIN1, S_ALU, S_DIV, S_WB, S_NOT, S_SW1, S_SW2,
    S_SW3, S_DUP, S_LOOP, S_EMIT, S_EXIT, S_DONE
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t  op;
    status_t st;
  } cmd_t;

  typedef struct packed {
    logic             halted;
    oper_t            oper;
    logic             ip_out;
    logic             row_ok;
    logic             len_full;
    logic             col_end;
    logic             rc_lt2;
    logic             ret_full;
    logic             dc_lt1;
    logic             dc_lt2;
    logic             dc_full;
    logic             cell_mark;
    logic             opc_neg;
    logic             opc_call;
    logic [OPC_W-1:0] opc;
    logic             div_done;
    logic             out_free;
  } dp_stat_t;

  function automatic logic [PROG_AW-1:0] prog_addr(input logic [LN_AW-1:0] line,
                                                   input logic [COL_W-1:0] col);
    prog_addr = PROG_AW'(line) * PROG_AW'(LINE_CELLS) + PROG_AW'(col);
  endfunction

endpackage

// ===== rtl/smi_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module smi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/smi_div.sv =====
// iterative signed divider, one quotient bit per cycle
// depends on smi_pkg
module smi_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [smi_pkg::CELL_BITS-1:0] dividend,
  input  logic [smi_pkg::CELL_BITS-1:0] divisor,
  output logic                          done,
  output logic [smi_pkg::CELL_BITS-1:0] quo,
  output logic [smi_pkg::CELL_BITS-1:0] rem
);
  import smi_pkg::*;

  localparam int CNT_W = $clog2(CELL_BITS + 1);

  logic                 busy_r, busy_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CELL_BITS-1:0] qd_r, qd_nxt;
  logic [CELL_BITS:0]   rm_r, rm_nxt;
  logic [CELL_BITS-1:0] ma_r, ma_nxt;
  logic                 negq_r, negq_nxt;
  logic                 negr_r, negr_nxt;
  logic [CELL_BITS:0]   trial;
  logic                 na, nb;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    qd_nxt   = qd_r;
    rm_nxt   = rm_r;
    ma_nxt   = ma_r;
    negq_nxt = negq_r;
    negr_nxt = negr_r;
    na       = divisor[CELL_BITS-1];
    nb       = dividend[CELL_BITS-1];
    trial    = {rm_r[CELL_BITS-1:0], qd_r[CELL_BITS-1]};
    if (start) begin
      if (divisor == '0) begin
        // zero divisor: quotient 0, remainder is the dividend
        qd_nxt   = '0;
        rm_nxt   = {1'b0, dividend};
        negq_nxt = 1'b0;
        negr_nxt = 1'b0;
      end else begin
        qd_nxt   = nb ? (~dividend + 1'b1) : dividend;
        ma_nxt   = na ? (~divisor + 1'b1) : divisor;
        rm_nxt   = '0;
        negq_nxt = na ^ nb;
        negr_nxt = nb;
        busy_nxt = 1'b1;
        cnt_nxt  = CNT_W'(CELL_BITS);
      end
    end else if (busy_r) begin
      if (trial >= {1'b0, ma_r}) begin
        rm_nxt = trial - {1'b0, ma_r};
        qd_nxt = {qd_r[CELL_BITS-2:0], 1'b1};
      end else begin
        rm_nxt = trial;
        qd_nxt = {qd_r[CELL_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    qd_r   <= qd_nxt;
    rm_r   <= rm_nxt;
    ma_r   <= ma_nxt;
    negq_r <= negq_nxt;
    negr_r <= negr_nxt;
  end

  assign done = !busy_r;
  assign quo  = negq_r ? (~qd_r + 1'b1) : qd_r;
  assign rem  = negr_r ? (~rm_r[CELL_BITS-1:0] + 1'b1) : rm_r[CELL_BITS-1:0];

endmodule

// ===== rtl/smi_dp.sv =====
// datapath: machine registers, stacks, program store, alu and result register
// depends on smi_pkg, smi_ram and smi_div
module smi_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_tuser,
  input  logic [47:0]       in_tdata,
  input  logic              out_tready,
  output logic              out_tvalid,
  output logic [47:0]       out_tdata,
  input  smi_pkg::cmd_t     cmd,
  output smi_pkg::dp_stat_t stat
);
  import smi_pkg::*;

  oper_t                op_r, op_nxt;
  logic [LINE_W-1:0]    row_r, row_nxt;
  logic [31:0]          num_r, num_nxt;
  logic [7:0]           rch_r, rch_nxt;
  logic [LINE_W-1:0]    ip_line_r, ip_line_nxt;
  logic [COL_W-1:0]     ip_col_r, ip_col_nxt;
  logic [LIU_W-1:0]     liu_r, liu_nxt;
  logic [DC_W-1:0]      dc_r, dc_nxt;
  logic [RC_W-1:0]      rc_r, rc_nxt;
  logic                 halted_r, halted_nxt;
  logic [NUM_LINES-1:0] len_vld_r, len_vld_nxt;
  logic                 lnv_r;
  logic [CELL_BITS-1:0] opc_r, opc_nxt;
  logic [CELL_BITS-1:0] a_r, a_nxt;
  logic [CELL_BITS-1:0] res_r, res_nxt;
  logic                 emit_v_r, emit_v_nxt;
  logic [7:0]           emit_c_r, emit_c_nxt;
  logic [31:0]          exit_r, exit_nxt;
  logic                 rdu_r, rdu_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic [OUT_TW-1:0]    out_data_r, out_data_nxt;

  // memory ports
  logic                 ds_we;
  logic [DS_AW-1:0]     ds_waddr, ds_raddr;
  logic [CELL_BITS-1:0] ds_wdata, ds_q;
  logic                 rs_we;
  logic [RS_AW-1:0]     rs_waddr, rs_raddr;
  logic [RET_W-1:0]     rs_wdata, rs_q;
  logic                 pg_we;
  logic [PROG_AW-1:0]   pg_waddr, pg_raddr;
  logic [CELL_BITS-1:0] pg_q;
  logic                 ln_we;
  logic [LN_AW-1:0]     ln_addr;
  logic [LEN_W-1:0]     ln_q, len_cur;

  logic                 div_start, div_done;
  logic [CELL_BITS-1:0] div_q, div_r;
  logic [OPC_W-1:0]     opc5;

  assign opc5     = opc_r[OPC_W-1:0];
  assign ln_addr  = (op_r == OPN_COMPILE) ? row_r[LN_AW-1:0] : ip_line_r[LN_AW-1:0];
  assign len_cur  = lnv_r ? ln_q : '0;
  assign pg_raddr = prog_addr(ip_line_r[LN_AW-1:0], ip_col_r);
  assign pg_waddr = prog_addr(row_r[LN_AW-1:0], len_cur);

  smi_ram #(.WIDTH(CELL_BITS), .DEPTH(DATA_DEPTH)) u_dstack (
    .clk(clk), .we(ds_we), .waddr(ds_waddr), .wdata(ds_wdata),
    .raddr(ds_raddr), .rdata(ds_q)
  );

  smi_ram #(.WIDTH(RET_W), .DEPTH(RETURN_DEPTH)) u_rstack (
    .clk(clk), .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(rs_raddr), .rdata(rs_q)
  );

  smi_ram #(.WIDTH(CELL_BITS), .DEPTH(PROG_DEPTH)) u_prog (
    .clk(clk), .we(pg_we), .waddr(pg_waddr), .wdata(CELL_BITS'(signed'(num_r))),
    .raddr(pg_raddr), .rdata(pg_q)
  );

  smi_ram #(.WIDTH(LEN_W), .DEPTH(NUM_LINES)) u_len (
    .clk(clk), .we(ln_we), .waddr(ln_addr), .wdata(len_cur + LEN_W'(1)),
    .raddr(ln_addr), .rdata(ln_q)
  );

  smi_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(ds_q), .divisor(a_r),
    .done(div_done), .quo(div_q), .rem(div_r)
  );

  always_comb begin
    op_nxt       = op_r;
    row_nxt      = row_r;
    num_nxt      = num_r;
    rch_nxt      = rch_r;
    ip_line_nxt  = ip_line_r;
    ip_col_nxt   = ip_col_r;
    liu_nxt      = liu_r;
    dc_nxt       = dc_r;
    rc_nxt       = rc_r;
    halted_nxt   = halted_r;
    len_vld_nxt  = len_vld_r;
    opc_nxt      = opc_r;
    a_nxt        = a_r;
    res_nxt      = res_r;
    emit_v_nxt   = emit_v_r;
    emit_c_nxt   = emit_c_r;
    exit_nxt     = exit_r;
    rdu_nxt      = rdu_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_data_nxt = out_data_r;
    ds_we        = 1'b0;
    ds_waddr     = DS_AW'(dc_r);
    ds_wdata     = ds_q;
    ds_raddr     = DS_AW'(dc_r - DC_W'(1));
    rs_we        = 1'b0;
    rs_waddr     = RS_AW'(rc_r);
    rs_wdata     = ip_line_r;
    rs_raddr     = RS_AW'(rc_r - RC_W'(1));
    pg_we        = 1'b0;
    ln_we        = 1'b0;
    div_start    = 1'b0;

    unique case (cmd.op)
      DP_NOP: begin
      end
      DP_LATCH: begin
        op_nxt     = oper_t'(in_tuser);
        row_nxt    = in_tdata[7:0];
        num_nxt    = in_tdata[39:8];
        rch_nxt    = in_tdata[47:40];
        emit_v_nxt = 1'b0;
        emit_c_nxt = '0;
        exit_nxt   = '0;
        rdu_nxt    = 1'b0;
      end
      DP_SET_IP: begin
        ip_line_nxt = row_r;
        ip_col_nxt  = '0;
      end
      DP_RESTART: begin
        ip_line_nxt = LINE_W'(FIRST_USER);
        ip_col_nxt  = '0;
      end
      DP_COMPILE: begin
        pg_we                 = 1'b1;
        ln_we                 = 1'b1;
        len_vld_nxt[ln_addr]  = 1'b1;
        if (liu_r < LIU_W'(row_r) + LIU_W'(1)) begin
          liu_nxt = LIU_W'(row_r) + LIU_W'(1);
        end
      end
      DP_RET_RD1: begin
      end
      DP_RET_RD2: begin
        ip_col_nxt = rs_q[COL_W-1:0];
        rs_raddr   = RS_AW'(rc_r - RC_W'(2));
      end
      DP_RET_DONE: begin
        ip_line_nxt = rs_q;
        rc_nxt      = rc_r - RC_W'(2);
      end
      DP_PROG_RD: begin
        ip_col_nxt = ip_col_r + COL_W'(1);
      end
      DP_PUSH_CELL: begin
        ds_we    = 1'b1;
        ds_wdata = pg_q;
        dc_nxt   = dc_r + DC_W'(1);
      end
      DP_POP_RD: begin
        dc_nxt = dc_r - DC_W'(1);
      end
      DP_OPC: begin
        opc_nxt = ds_q;
      end
      DP_CALL1: begin
        rs_we  = 1'b1;
        rc_nxt = rc_r + RC_W'(1);
      end
      DP_CALL2: begin
        rs_we       = 1'b1;
        rs_wdata    = RET_W'(ip_col_r);
        rc_nxt      = rc_r + RC_W'(1);
        ip_line_nxt = (opc_r > CELL_BITS'(FAR_LINE)) ? LINE_W'(FAR_LINE)
                                                      : opc_r[LINE_W-1:0];
        ip_col_nxt  = '0;
      end
      DP_BIN1: begin
        a_nxt    = ds_q;
        ds_raddr = DS_AW'(dc_r - DC_W'(2));
      end
      DP_ALU: begin
        // ds_q is the second operand, a_r the top
        case (opc5)
          IN_ADD:  res_nxt = a_r + ds_q;
          IN_SUB:  res_nxt = ds_q - a_r;
          IN_MUL:  res_nxt = CELL_BITS'(a_r * ds_q);
          IN_AND:  res_nxt = CELL_BITS'((a_r != '0) && (ds_q != '0));
          IN_OR:   res_nxt = CELL_BITS'((a_r != '0) || (ds_q != '0));
          default: res_nxt = '0;
        endcase
        div_start = (opc5 == IN_DIV) || (opc5 == IN_MOD);
      end
      DP_DIVCAP: begin
        res_nxt = (opc5 == IN_DIV) ? div_q : div_r;
      end
      DP_WB: begin
        ds_we    = 1'b1;
        ds_waddr = DS_AW'(dc_r - DC_W'(2));
        ds_wdata = res_r;
        dc_nxt   = dc_r - DC_W'(1);
      end
      DP_NOT: begin
        ds_we    = 1'b1;
        ds_waddr = DS_AW'(dc_r - DC_W'(1));
        ds_wdata = CELL_BITS'(ds_q == '0);
      end
      DP_SW2: begin
        ds_we    = 1'b1;
        ds_waddr = DS_AW'(dc_r - DC_W'(1));
      end
      DP_SW3: begin
        ds_we    = 1'b1;
        ds_waddr = DS_AW'(dc_r - DC_W'(2));
        ds_wdata = a_r;
      end
      DP_DUP: begin
        ds_we  = 1'b1;
        dc_nxt = dc_r + DC_W'(1);
      end
      DP_DROP: begin
        dc_nxt = dc_r - DC_W'(1);
      end
      DP_LOOP: begin
        if (ds_q == '0) begin
          dc_nxt = dc_r - DC_W'(1);
        end else begin
          ip_col_nxt = '0;
        end
      end
      DP_EMIT: begin
        if (!ds_q[CELL_BITS-1] && ds_q < CELL_BITS'(255)) begin
          emit_v_nxt = 1'b1;
          emit_c_nxt = ds_q[7:0];
        end
      end
      DP_READ: begin
        rdu_nxt = 1'b1;
        if (dc_r < DC_W'(DATA_DEPTH)) begin
          ds_we    = 1'b1;
          ds_wdata = CELL_BITS'(signed'(rch_r));
          dc_nxt   = dc_r + DC_W'(1);
        end
      end
      DP_EXIT: begin
        exit_nxt = 32'(signed'(ds_q));
      end
      DP_DONE: begin
        out_vld_nxt  = 1'b1;
        out_data_nxt = {3'b000, rdu_r, exit_r, emit_c_r, emit_v_r, cmd.st};
        if (cmd.st >= ST_EXIT && cmd.st <= ST_ROVER) begin
          halted_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_line_r <= '0;
      ip_col_r  <= '0;
      liu_r     <= '0;
      dc_r      <= '0;
      rc_r      <= '0;
      halted_r  <= 1'b0;
      len_vld_r <= '0;
      out_vld_r <= 1'b0;
    end else begin
      ip_line_r <= ip_line_nxt;
      ip_col_r  <= ip_col_nxt;
      liu_r     <= liu_nxt;
      dc_r      <= dc_nxt;
      rc_r      <= rc_nxt;
      halted_r  <= halted_nxt;
      len_vld_r <= len_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
    op_r       <= op_nxt;
    row_r      <= row_nxt;
    num_r      <= num_nxt;
    rch_r      <= rch_nxt;
    lnv_r      <= len_vld_r[ln_addr];
    opc_r      <= opc_nxt;
    a_r        <= a_nxt;
    res_r      <= res_nxt;
    emit_v_r   <= emit_v_nxt;
    emit_c_r   <= emit_c_nxt;
    exit_r     <= exit_nxt;
    rdu_r      <= rdu_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    stat.halted    = halted_r;
    stat.oper      = op_r;
    stat.ip_out    = ip_line_r >= LINE_W'(liu_r);
    stat.row_ok    = (row_r >= LINE_W'(FIRST_USER)) && (row_r != LINE_W'(CALL_MARK)) &&
                     (row_r < LINE_W'(NUM_LINES));
    stat.len_full  = len_cur >= LEN_W'(LINE_CELLS);
    stat.col_end   = ip_col_r >= len_cur;
    stat.rc_lt2    = rc_r < RC_W'(2);
    stat.ret_full  = rc_r > RC_W'(RETURN_DEPTH - 2);
    stat.dc_lt1    = dc_r == '0;
    stat.dc_lt2    = dc_r < DC_W'(2);
    stat.dc_full   = dc_r >= DC_W'(DATA_DEPTH);
    stat.cell_mark = pg_q == CELL_BITS'(CALL_MARK);
    stat.opc_neg   = opc_r[CELL_BITS-1];
    stat.opc_call  = !opc_r[CELL_BITS-1] && (opc_r >= CELL_BITS'(FIRST_USER));
    stat.opc       = opc5;
    stat.div_done  = div_done;
    stat.out_free  = !out_vld_r || out_tready;
  end

endmodule

// ===== rtl/smi_ctrl.sv =====
// controller: sequences each item through datapath commands
// depends on smi_pkg
module smi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  smi_pkg::dp_stat_t stat,
  output smi_pkg::cmd_t     cmd
);
  import smi_pkg::*;

  ctrl_state_t state_r, state_nxt;
  status_t     st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    st_nxt    = st_r;
    cmd.op    = DP_NOP;
    cmd.st    = st_r;
    in_tready = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = DP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_DONE;
        st_nxt    = ST_OK;
        if (stat.halted) begin
          st_nxt = ST_HALTED;
        end else begin
          unique case (stat.oper)
            OPN_COMPILE: begin
              if (!stat.row_ok) begin
                st_nxt = ST_DROPPED;
              end else begin
                state_nxt = S_CMP1;
              end
            end
            OPN_STEP: begin
              if (stat.ip_out) begin
                cmd.op = DP_RESTART;
              end else begin
                state_nxt = S_STEP1;
              end
            end
            OPN_SETIP: cmd.op = DP_SET_IP;
            default: begin
            end
          endcase
        end
      end
      S_CMP1: begin
        state_nxt = S_DONE;
        if (stat.len_full) begin
          st_nxt = ST_DROPPED;
        end else begin
          cmd.op = DP_COMPILE;
        end
      end
      S_STEP1: begin
        if (stat.col_end) begin
          if (stat.rc_lt2) begin
            st_nxt    = ST_RUNDER;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = DP_RET_RD1;
            state_nxt = S_RET1;
          end
        end else begin
          cmd.op    = DP_PROG_RD;
          state_nxt = S_CELL;
        end
      end
      S_RET1: begin
        cmd.op    = DP_RET_RD2;
        state_nxt = S_RET2;
      end
      S_RET2: begin
        cmd.op    = DP_RET_DONE;
        state_nxt = S_DONE;
      end
      S_CELL: begin
        state_nxt = S_DONE;
        if (!stat.cell_mark) begin
          if (stat.dc_full) begin
            st_nxt = ST_DOVER;
          end else begin
            cmd.op = DP_PUSH_CELL;
          end
        end else if (stat.dc_lt1) begin
          st_nxt = ST_DUNDER;
        end else begin
          cmd.op    = DP_POP_RD;
          state_nxt = S_OPC;
        end
      end
      S_OPC: begin
        cmd.op    = DP_OPC;
        state_nxt = S_DEC;
      end
      S_DEC: begin
        state_nxt = S_DONE;
        if (stat.opc_neg) begin
          st_nxt = ST_OK;
        end else if (stat.opc_call) begin
          if (stat.ret_full) begin
            st_nxt = ST_ROVER;
          end else begin
            cmd.op    = DP_CALL1;
            state_nxt = S_CALL2;
          end
        end else begin
          unique case (stat.opc) inside
            IN_ADD, IN_SUB, IN_MUL, IN_DIV, IN_MOD, IN_AND, IN_OR: begin
              if (stat.dc_lt2) st_nxt = ST_DUNDER;
              else state_nxt = S_BIN1;
            end
            IN_SWAP: begin
              if (stat.dc_lt2) st_nxt = ST_DUNDER;
              else state_nxt = S_SW1;
            end
            IN_NOT: begin
              if (stat.dc_lt1) st_nxt = ST_DUNDER;
              else state_nxt = S_NOT;
            end
            IN_DUP: begin
              if (stat.dc_lt1) st_nxt = ST_DUNDER;
              else if (stat.dc_full) st_nxt = ST_DOVER;
              else state_nxt = S_DUP;
            end
            IN_DROP: begin
              if (stat.dc_lt1) st_nxt = ST_DUNDER;
              else cmd.op = DP_DROP;
            end
            IN_LOOP: begin
              if (stat.dc_lt1) st_nxt = ST_DUNDER;
              else state_nxt = S_LOOP;
            end
            IN_EMIT: begin
              if (stat.dc_lt1) begin
                st_nxt = ST_DUNDER;
              end else begin
                cmd.op    = DP_POP_RD;
                state_nxt = S_EMIT;
              end
            end
            IN_READ: begin
              cmd.op = DP_READ;
              st_nxt = stat.dc_full ? ST_DOVER : ST_OK;
            end
            default: begin
              // exit
              if (stat.dc_lt1) begin
                st_nxt = ST_DUNDER;
              end else begin
                cmd.op    = DP_POP_RD;
                state_nxt = S_EXIT;
              end
            end
          endcase
        end
      end
      S_CALL2: begin
        cmd.op    = DP_CALL2;
        state_nxt = S_DONE;
      end
      S_BIN1: begin
        cmd.op    = DP_BIN1;
        state_nxt = S_ALU;
      end
      S_ALU: begin
        cmd.op    = DP_ALU;
        state_nxt = (stat.opc == IN_DIV || stat.opc == IN_MOD) ? S_DIV : S_WB;
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.op    = DP_DIVCAP;
          state_nxt = S_WB;
        end
      end
      S_WB: begin
        cmd.op    = DP_WB;
        state_nxt = S_DONE;
      end
      S_NOT: begin
        cmd.op    = DP_NOT;
        state_nxt = S_DONE;
      end
      S_SW1: begin
        cmd.op    = DP_BIN1;
        state_nxt = S_SW2;
      end
      S_SW2: begin
        cmd.op    = DP_SW2;
        state_nxt = S_SW3;
      end
      S_SW3: begin
        cmd.op    = DP_SW3;
        state_nxt = S_DONE;
      end
      S_DUP: begin
        cmd.op    = DP_DUP;
        state_nxt = S_DONE;
      end
      S_LOOP: begin
        cmd.op    = DP_LOOP;
        state_nxt = S_DONE;
      end
      S_EMIT: begin
        cmd.op    = DP_EMIT;
        state_nxt = S_DONE;
      end
      S_EXIT: begin
        cmd.op    = DP_EXIT;
        st_nxt    = ST_EXIT;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.op    = DP_DONE;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/stack_machine_interpreter_core.sv =====
// top level of the stack machine interpreter core
// depends on smi_pkg, smi_ctrl and smi_dp (which holds smi_ram and smi_div)
//
// usage
//   input beats carry one command each: compile a cell into a program line,
//   run one interpreter tick, set the instruction pointer to a line or do
//   nothing; every accepted beat gives exactly one result beat with a status
//   code, the emitted character, the exit code and a read-used flag
// sequencing
//   one item at a time; the next beat is taken only once the previous
//   item has put its result into the output register; divide and modulo
//   wait on the bit-serial divider, and stack and program accesses each go
//   through a registered ram read
// reset
//   synchronous active-low reset clears stack counts, line lengths, the
//   instruction pointer and the halt flag; no clearing pass is needed
// back-pressure
//   the result sits in an output register, so a new input beat is taken
//   while it waits; the next item then holds in its last step until the
//   receiver takes the pending beat
module stack_machine_interpreter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // row[7:0], number[39:8], read_char[47:40]
  input  logic [1:0]  in_tuser,   // operation[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[2:0], emit_valid[3], emit_char[11:4],
                                  // exit_code[43:12], read_used[44], zero pad
);
  import smi_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;

  // sequencing of each item
  smi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .stat(stat), .cmd(cmd)
  );

  // machine state, memories and result register
  smi_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .out_tdata(out_tdata),
    .cmd(cmd), .stat(stat)
  );

endmodule

// ===== rtl/smi_checker.sv =====
// port-level checks of the stack machine interpreter core, bound to the top
// depends on the top level port list only
module smi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [47:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata
);

  // result beat held while stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat dropped or changed while stalled");

  // nothing to deliver right after reset
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result beat right after reset");

  // ignored item carries no side results
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == 3'd7 |->
      out_tdata[3] == 1'b0 && out_tdata[43:12] == 32'd0 && out_tdata[44] == 1'b0)
    else $error("side results on an ignored item");

  // no emitted character unless flagged
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[3] |-> out_tdata[11:4] == 8'd0)
    else $error("character without emit flag");

  // exit code only with exit status
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] != 3'd1 |-> out_tdata[43:12] == 32'd0)
    else $error("exit code without exit status");

endmodule

bind stack_machine_interpreter_core smi_checker u_smi_checker (.*);

// ===== test/smi_checker.sv =====
`timescale 1ns / 100ps
// scoreboard for the stack machine interpreter core: watches both stream channels,
// predicts each result beat and compares it; depends on smi_pkg only
module smi_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  output int          fails,
  output int          pending
);
  import smi_pkg::*;

  typedef struct packed {
    logic        read_used;
    logic [31:0] exit_code;
    logic [7:0]  emit_char;
    logic        emit_valid;
    status_t     status;
  } result_t;

  logic [31:0] dstk [DATA_DEPTH];
  logic [7:0]  rstk [RETURN_DEPTH];
  logic [31:0] prog [NUM_LINES][LINE_CELLS];
  int          llen [NUM_LINES];
  int          dcnt, rcnt, inuse, ipl, ipc;
  bit          halted;
  result_t     expected_q [$];

  function automatic logic [31:0] signed_div(input logic [31:0] b, input logic [31:0] a,
                                             input bit want_rem);
    logic [31:0] ma, mb, q, r;
    if (a == 0) return want_rem ? b : 32'd0;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    q  = mb / ma;
    r  = mb % ma;
    if (want_rem) return b[31] ? -r : r;
    return (a[31] != b[31]) ? -q : q;
  endfunction

  function automatic status_t run_intrinsic(input logic [4:0] opc, input logic [7:0] rc,
                                            inout result_t res);
    logic [31:0] a, b, w;
    if (opc <= IN_OR) begin
      if (dcnt < 2) return ST_DUNDER;
      a = dstk[dcnt-1];
      b = dstk[dcnt-2];
      dcnt -= 2;
      case (opc)
        IN_ADD:  w = a + b;
        IN_SUB:  w = b - a;
        IN_MUL:  w = a * b;
        IN_DIV:  w = signed_div(b, a, 0);
        IN_MOD:  w = signed_div(b, a, 1);
        IN_AND:  w = (a != 0 && b != 0) ? 32'd1 : 32'd0;
        default: w = (a != 0 || b != 0) ? 32'd1 : 32'd0;
      endcase
      dstk[dcnt] = w;
      dcnt++;
      return ST_OK;
    end
    case (opc)
      IN_NOT: begin
        if (dcnt < 1) return ST_DUNDER;
        dstk[dcnt-1] = (dstk[dcnt-1] == 0) ? 32'd1 : 32'd0;
      end
      IN_SWAP: begin
        if (dcnt < 2) return ST_DUNDER;
        a = dstk[dcnt-1];
        dstk[dcnt-1] = dstk[dcnt-2];
        dstk[dcnt-2] = a;
      end
      IN_DUP: begin
        if (dcnt < 1) return ST_DUNDER;
        if (dcnt >= DATA_DEPTH) return ST_DOVER;
        dstk[dcnt] = dstk[dcnt-1];
        dcnt++;
      end
      IN_DROP: begin
        if (dcnt < 1) return ST_DUNDER;
        dcnt--;
      end
      IN_LOOP: begin
        if (dcnt < 1) return ST_DUNDER;
        if (dstk[dcnt-1] == 0) dcnt--;
        else ipc = 0;
      end
      IN_EMIT: begin
        if (dcnt < 1) return ST_DUNDER;
        dcnt--;
        a = dstk[dcnt];
        if (!a[31] && a < 255) begin
          res.emit_valid = 1'b1;
          res.emit_char  = a[7:0];
        end
      end
      IN_READ: begin
        res.read_used = 1'b1;
        if (dcnt >= DATA_DEPTH) return ST_DOVER;
        dstk[dcnt] = {{24{rc[7]}}, rc};
        dcnt++;
      end
      default: begin
        // every code above read is exit
        if (dcnt < 1) return ST_DUNDER;
        dcnt--;
        res.exit_code = dstk[dcnt];
        halted = 1'b1;
        return ST_EXIT;
      end
    endcase
    return ST_OK;
  endfunction

  function automatic status_t run_tick(input logic [7:0] rc, inout result_t res);
    logic [31:0] v;
    if (ipl >= inuse) begin
      ipl = FIRST_USER;
      ipc = 0;
      return ST_OK;
    end
    if (ipc >= llen[ipl]) begin
      if (rcnt < 2) return ST_RUNDER;
      rcnt--;
      ipc = rstk[rcnt];
      rcnt--;
      ipl = rstk[rcnt];
      return ST_OK;
    end
    v = prog[ipl][ipc];
    ipc++;
    if (v != CALL_MARK) begin
      if (dcnt >= DATA_DEPTH) return ST_DOVER;
      dstk[dcnt] = v;
      dcnt++;
      return ST_OK;
    end
    if (dcnt < 1) return ST_DUNDER;
    dcnt--;
    v = dstk[dcnt];
    if (v[31]) return ST_OK;   // negative opcode is swallowed
    if (v < FIRST_USER) return run_intrinsic(v[4:0], rc, res);
    if (rcnt + 2 > RETURN_DEPTH) return ST_ROVER;
    rstk[rcnt] = ipl[7:0];
    rstk[rcnt+1] = ipc[7:0];
    rcnt += 2;
    ipl = (v > FAR_LINE) ? FAR_LINE : int'(v);
    ipc = 0;
    return ST_OK;
  endfunction

  function automatic result_t machine_beat(input oper_t op, input logic [7:0] row,
                                           input logic [31:0] num, input logic [7:0] rc);
    result_t res;
    res = '0;
    res.status = ST_OK;
    if (halted) begin
      res.status = ST_HALTED;
    end else if (op == OPN_COMPILE) begin
      if (row >= FIRST_USER && row != CALL_MARK && row < NUM_LINES &&
          llen[row] < LINE_CELLS) begin
        prog[row][llen[row]] = num;
        llen[row]++;
        if (inuse < row + 1) inuse = row + 1;
      end else begin
        res.status = ST_DROPPED;
      end
    end else if (op == OPN_STEP) begin
      res.status = run_tick(rc, res);
      if (res.status >= ST_DUNDER) halted = 1'b1;
    end else if (op == OPN_SETIP) begin
      ipl = row;
      ipc = 0;
    end
    return res;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      foreach (llen[i]) llen[i] = 0;
      dcnt = 0; rcnt = 0; inuse = 0; ipl = 0; ipc = 0;
      halted = 1'b0;
      expected_q.delete();
      fails = 0;
    end else begin
      if (in_tvalid && in_tready)
        expected_q.insert(expected_q.size(),
                          machine_beat(oper_t'(in_tuser), in_tdata[7:0],
                                       in_tdata[39:8], in_tdata[47:40]));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result beat %h with nothing expected", $time, out_tdata);
          fails++;
        end else begin
          want = expected_q.pop_front();
          if (out_tdata !== {3'b000, want}) begin
            $display("%0t: mismatch expected %h (status %0d) actual %h (status %0d)",
                     $time, {3'b000, want}, want.status, out_tdata, out_tdata[2:0]);
            fails++;
          end
        end
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// top of the stack machine interpreter core testbench: builds stack-safe
// programs, runs them beat by beat and gives the verdict; needs smi_pkg,
// the core and smi_scoreboard
module tb;
  import smi_pkg::*;

  localparam logic [4:0] OPC_EXIT  = IN_READ + 5'd1;
  localparam int         FIRST_LEAF = FIRST_USER;
  localparam int         LAST_LEAF  = FIRST_USER + 4;
  localparam int         EXIT_LINE  = NUM_LINES - 1;
  localparam int         WANT_ITEMS = 1750;
  localparam int         STALL_LIMIT = 5000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // row[7:0], number[39:8], read_char[47:40]
  logic [1:0]  in_tuser = '0;   // operation[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // status[2:0], emit_valid[3], emit_char[11:4],
                                // exit_code[43:12], read_used[44], zero pad
  int          fails, pending;

  // line bookkeeping on the stimulus side: cells written and ticks to run a
  // line from column 0 to its end (not counting the return tick)
  int          line_len  [NUM_LINES];
  int          line_cost [NUM_LINES];
  logic [31:0] grp [$];
  int          grp_cost;
  int          sent, useful, cyc, idle_cyc;
  bit          quiet;
  bit          drained;

  stack_machine_interpreter_core i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata
  );

  smi_scoreboard i_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .fails, .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stalls, one long hold-off so the core backs up, and a
  // stretch of constant readiness
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= 2000 && cyc < 2300) out_tready <= 1'b0;
    else if (cyc >= 6000 && cyc < 9000) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 99) >= 21);
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= STALL_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_beat(input oper_t op, input logic [7:0] row, input logic [31:0] num);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {8'($urandom), num, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    if (!quiet && $urandom_range(0, 99) < 21) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // data value for a cell; the call mark can never be pushed as data
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0: v = 32'h8000_0000;
      1: v = 32'h7fff_ffff;
      2: v = 32'hffff_ffff;
      3: v = 32'd0;
      4, 5: v = $urandom;
      default: v = $urandom_range(0, 300);
    endcase
    return (v == CALL_MARK) ? 32'd43 : v;
  endfunction

  // one stack-neutral fragment; leaf lines never call
  task automatic make_group(input bit leaf);
    logic [31:0] a, b, t;
    a = pick_value();
    b = pick_value();
    grp.delete();
    grp_cost = 0;
    case ($urandom_range(0, leaf ? 7 : 9))
      0: grp = '{a, b, 32'($urandom_range(IN_ADD, IN_OR)), CALL_MARK, 32'(IN_EMIT), CALL_MARK};
      1: grp = '{a, 32'(IN_NOT), CALL_MARK, 32'(IN_EMIT), CALL_MARK};
      2: grp = '{a, 32'(IN_DUP), CALL_MARK, 32'(IN_ADD), CALL_MARK, 32'(IN_EMIT), CALL_MARK};
      3: grp = '{a, b, 32'(IN_SWAP), CALL_MARK, 32'(IN_EMIT), CALL_MARK,
                 32'(IN_EMIT), CALL_MARK};
      4: grp = '{32'(IN_READ), CALL_MARK, 32'(IN_EMIT), CALL_MARK};
      5: grp = '{a, 32'(IN_DROP), CALL_MARK};
      6: grp = '{32'd0, 32'(IN_LOOP), CALL_MARK};     // zero top falls through
      7: grp = '{$urandom | 32'h8000_0000, CALL_MARK}; // negative opcode
      8: begin
        t = $urandom_range(FIRST_LEAF, LAST_LEAF);
        grp = '{t, CALL_MARK};
        grp_cost = 3 + line_cost[t];
      end
      default: begin
        // target off the program: saturates, restarts at the first line, returns
        case ($urandom_range(0, 2))
          0: t = FAR_LINE;
          1: t = 32'h7fff_ffff;
          default: t = 256 + $urandom_range(0, 100000);
        endcase
        grp = '{t, CALL_MARK};
        grp_cost = 4 + line_cost[FIRST_USER];
      end
    endcase
    if (grp_cost == 0) grp_cost = grp.size();
  endtask

  task automatic compile_group(input int row);
    foreach (grp[i]) send_beat(OPN_COMPILE, 8'(row), grp[i]);
    line_len[row]  += grp.size();
    line_cost[row] += grp_cost;
  endtask

  task automatic run_line(input int row);
    send_beat(OPN_SETIP, 8'(row), $urandom);
    repeat (line_cost[row]) send_beat(OPN_STEP, 8'($urandom), $urandom);
  endtask

  task automatic noise_beat();
    int r;
    case ($urandom_range(0, 3))
      0: send_beat(OPN_NOP, 8'($urandom), $urandom);
      1: send_beat(OPN_SETIP, 8'($urandom), $urandom);
      default: begin
        // rows the core must refuse, or a line that is already full
        r = $urandom_range(0, 3);
        if (r == 0) r = $urandom_range(0, FIRST_USER - 1);
        else if (r == 1) r = CALL_MARK;
        else if (r == 2) r = $urandom_range(NUM_LINES, 255);
        else begin
          r = $urandom_range(FIRST_USER, EXIT_LINE - 1);
          if (line_len[r] < LINE_CELLS) r = CALL_MARK;
        end
        send_beat(OPN_COMPILE, 8'(r), $urandom);
      end
    endcase
  endtask

  initial begin
    int row, tries, k;
    foreach (line_len[i]) begin
      line_len[i]  = 0;
      line_cost[i] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // leaf lines that other lines call into
    for (int l = FIRST_LEAF; l <= LAST_LEAF; l++) begin
      make_group(1'b1);
      compile_group(l);
    end
    // division corners: by zero, and most negative by minus one
    grp = '{32'd7, 32'd0, 32'(IN_DIV), CALL_MARK, 32'(IN_EMIT), CALL_MARK,
            32'd9, 32'd0, 32'(IN_MOD), CALL_MARK, 32'(IN_EMIT), CALL_MARK,
            32'h8000_0000, 32'hffff_ffff, 32'(IN_DIV), CALL_MARK, 32'(IN_EMIT), CALL_MARK,
            32'h8000_0000, 32'hffff_ffff, 32'(IN_MOD), CALL_MARK, 32'(IN_EMIT), CALL_MARK};
    grp_cost = grp.size();
    compile_group(LAST_LEAF + 1);
    run_line(LAST_LEAF + 1);
    // refused rows, no-op, and a tick from outside the program
    send_beat(OPN_COMPILE, 8'd0, 32'hffff_ffff);
    send_beat(OPN_COMPILE, 8'(FIRST_USER - 1), 32'd1);
    send_beat(OPN_COMPILE, 8'(CALL_MARK), 32'd1);
    send_beat(OPN_COMPILE, 8'(NUM_LINES), 32'd1);
    send_beat(OPN_COMPILE, 8'hff, 32'h8000_0000);
    send_beat(OPN_NOP, 8'hff, 32'hffff_ffff);
    send_beat(OPN_SETIP, 8'd200, 32'd0);
    send_beat(OPN_STEP, 8'd0, 32'd0);

    // random programs: grow lines, run them from the top, sprinkle noise
    while (useful < WANT_ITEMS) begin
      quiet = (useful >= 500 && useful < 800);
      if (!drained && useful >= 900) begin
        // sender pauses until every result is back
        drained = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      k = $urandom_range(0, 99);
      if (k < 45) begin
        make_group(1'b0);
        for (tries = 0; tries < 8; tries++) begin
          row = $urandom_range(LAST_LEAF + 1, EXIT_LINE - 1);
          if (row != CALL_MARK && line_len[row] + grp.size() <= LINE_CELLS) break;
        end
        if (tries < 8) begin
          compile_group(row);
          useful += grp.size();
        end
      end else if (k < 85) begin
        row = $urandom_range(FIRST_LEAF, EXIT_LINE - 1);
        if (line_cost[row] > 0) begin
          run_line(row);
          useful += line_cost[row] + 1;
        end
      end else begin
        noise_beat();
      end
    end

    // exit halts for good; later beats are ignored
    grp = '{pick_value(), 32'(OPC_EXIT + 5'($urandom_range(0, 6))), CALL_MARK};
    grp_cost = grp.size();
    compile_group(EXIT_LINE);
    run_line(EXIT_LINE);
    send_beat(OPN_STEP, 8'd0, 32'd0);
    send_beat(OPN_COMPILE, 8'(FIRST_USER), 32'd5);
    send_beat(OPN_SETIP, 8'(FIRST_USER), 32'd0);
    in_tvalid <= 1'b0;
    @(posedge clk);

    wait (pending == 0);
    repeat (60) @(posedge clk);
    $display("%0d command beats sent: compiles, ticks, pointer sets and no-ops", sent);
    $display("programs with calls, far calls, all intrinsics, division corners, exit halt");
    if (fails == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/smi_pkg.sv
rtl/smi_ram.sv
rtl/smi_div.sv
rtl/smi_dp.sv
rtl/smi_ctrl.sv
rtl/stack_machine_interpreter_core.sv
rtl/smi_checker.sv
test/smi_checker.sv
test/tb.sv
